FILE: rtl/tzkeg_pkg.sv
`timescale 1ns / 1ps

package tzkeg_pkg;

    // Default build values
    localparam int NUM_KEYS_DEF    = 13;
    localparam int PANEL_WIDTH_DEF = 320;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int RR_W    = 3;
    localparam int COORD_W = 9;
    localparam int POLL_W  = 10;
    localparam int HOLD_W  = 12;
    localparam int CODE_W  = 8;
    localparam int KIDX_W  = 4;
    localparam int LY_W    = 12;
    localparam int ZKEYS   = 13;

    // Packed word widths
    localparam int IN_BITS  = TIME_W + RR_W + 4 * COORD_W + 2;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 3 + KIDX_W + CODE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] REG_POLL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ABORT   = 2'd3;

    localparam logic [POLL_W-1:0] POLL_RST    = 10'd25;
    localparam logic [HOLD_W-1:0] HOLD_RST    = 12'd150;
    localparam logic [CODE_W-1:0] CONFIRM_RST = 8'd121;
    localparam logic [CODE_W-1:0] ABORT_RST   = 8'd110;

    // Logical keys
    localparam int KI_FWD   = 0;
    localparam int KI_BACK  = 1;
    localparam int KI_TURNL = 2;
    localparam int KI_TURNR = 3;
    localparam int KI_STRL  = 4;
    localparam int KI_STRR  = 5;
    localparam int KI_FIRE  = 6;
    localparam int KI_USE   = 7;
    localparam int KI_ESC   = 8;
    localparam int KI_ENTER = 9;
    localparam int KI_MAP   = 10;
    localparam int KI_YES   = 11;
    localparam int KI_NO    = 12;

    // Landscape zone bounds
    localparam logic signed [LY_W-1:0] ZONE_ROW1 = 12'sd80;
    localparam logic signed [LY_W-1:0] ZONE_ROW3 = 12'sd240;
    localparam logic signed [LY_W-1:0] MOVE_CY   = 12'sd160;
    localparam logic signed [LY_W-1:0] MOVE_SY0  = 12'sd144;
    localparam logic signed [LY_W-1:0] MOVE_SY1  = 12'sd176;
    localparam logic [COORD_W-1:0] ZONE_HALF_X = 9'd240;
    localparam logic [COORD_W-1:0] MOVE_X_END  = 9'd160;
    localparam logic [COORD_W-1:0] MOVE_CX     = 9'd80;
    localparam logic [COORD_W-1:0] TURN_X0     = 9'd320;
    localparam logic [COORD_W-1:0] TURN_XM     = 9'd400;

    typedef logic [ZKEYS-1:0] zkeys_t;

    function automatic zkeys_t kbit(input int k);
        zkeys_t r;
        r = '0;
        r[k] = 1'b1;
        return r;
    endfunction

    function automatic zkeys_t game_zone(input logic [COORD_W-1:0] lx,
                                         input logic signed [LY_W-1:0] ly);
        zkeys_t r;
        if (ly < ZONE_ROW1)
            r = (lx < ZONE_HALF_X) ? kbit(KI_ESC) : kbit(KI_MAP);
        else if (ly >= ZONE_ROW3)
            r = (lx < ZONE_HALF_X) ? kbit(KI_USE) : kbit(KI_FIRE);
        else if (lx < MOVE_X_END)
        begin
            if (ly < MOVE_SY0)
                r = kbit(KI_FWD);
            else if (ly >= MOVE_SY1)
                r = kbit(KI_BACK);
            else
                r = (lx < MOVE_CX) ? kbit(KI_STRL) : kbit(KI_STRR);
        end
        else if (lx >= TURN_X0)
            r = (lx < TURN_XM) ? kbit(KI_TURNL) : kbit(KI_TURNR);
        else
            r = '0;
        return r;
    endfunction

    function automatic zkeys_t menu_zone(input logic [COORD_W-1:0] lx,
                                         input logic signed [LY_W-1:0] ly);
        zkeys_t r;
        if (ly < ZONE_ROW1)
            r = (lx < ZONE_HALF_X) ? kbit(KI_ESC) : kbit(KI_ENTER);
        else if (ly >= ZONE_ROW3)
            r = kbit(KI_ENTER);
        else if (lx < MOVE_X_END)
            r = (ly < MOVE_CY) ? kbit(KI_FWD) : kbit(KI_BACK);
        else if (lx >= TURN_X0)
            r = (lx < TURN_XM) ? kbit(KI_TURNL) : kbit(KI_TURNR);
        else
            r = kbit(KI_ENTER);
        return r;
    endfunction

    function automatic zkeys_t prompt_zone(input logic [COORD_W-1:0] lx,
                                           input logic signed [LY_W-1:0] ly);
        zkeys_t r;
        if (ly < ZONE_ROW1 && lx < ZONE_HALF_X)
            r = kbit(KI_NO);
        else
            r = kbit(KI_YES);
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] base_code(input logic [KIDX_W-1:0] idx);
        logic [CODE_W-1:0] c;
        case (idx)
            4'd0:    c = 8'had;
            4'd1:    c = 8'haf;
            4'd2:    c = 8'hac;
            4'd3:    c = 8'hae;
            4'd4:    c = 8'ha0;
            4'd5:    c = 8'ha1;
            4'd6:    c = 8'ha3;
            4'd7:    c = 8'ha2;
            4'd8:    c = 8'd27;
            4'd9:    c = 8'd13;
            4'd10:   c = 8'd9;
            4'd11:   c = 8'd121;
            4'd12:   c = 8'd110;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/touch_zone_key_event_generator.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                          Word
// s_*       in   s_tvalid s_tready s_tdata        one touch request
// m_*       out  m_tvalid m_tready m_tdata        one result word per request
// cfg_*     in   cfg_valid cfg_ready cfg_index    one register write
//                cfg_data
//
// One request per cycle: sampling, zone mapping and the lowest-index change
// pick all settle in the cycle a word is accepted, into the result register.
// s_tready drops only while a result waits and m_tready is low.
// rst_n clears all key state and times and loads the register defaults.
// cfg_ready is always high.
module touch_zone_key_event_generator #(
    parameter int NUM_KEYS    = tzkeg_pkg::NUM_KEYS_DEF,
    parameter int PANEL_WIDTH = tzkeg_pkg::PANEL_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms, read_result, point0_x, point0_y, point1_x, point1_y,
    // menu_active, prompt_active, zero fill
    input  logic [tzkeg_pkg::IN_W-1:0]         s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sample_taken, event_valid, key_pressed, key_index, key_code, zero fill
    output logic [tzkeg_pkg::OUT_W-1:0]        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tzkeg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tzkeg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int TW = tzkeg_pkg::TIME_W;
    localparam int CW = tzkeg_pkg::COORD_W;
    localparam int LW = tzkeg_pkg::LY_W;
    localparam int KW = tzkeg_pkg::KIDX_W;
    localparam int DW = tzkeg_pkg::CODE_W;
    localparam logic signed [LW-1:0] LY_TOP = LW'(PANEL_WIDTH - 1);

    // Request fields
    logic [TW-1:0]      now_ms;
    logic [2:0]         read_result;
    logic [CW-1:0]      p0x, p0y, p1x, p1y;
    logic               menu_active, prompt_active;

    assign now_ms        = s_tdata[TW-1:0];
    assign read_result   = s_tdata[TW+2:TW];
    assign p0x           = s_tdata[TW+3+CW-1:TW+3];
    assign p0y           = s_tdata[TW+3+2*CW-1:TW+3+CW];
    assign p1x           = s_tdata[TW+3+3*CW-1:TW+3+2*CW];
    assign p1y           = s_tdata[TW+3+4*CW-1:TW+3+3*CW];
    assign menu_active   = s_tdata[TW+3+4*CW];
    assign prompt_active = s_tdata[TW+3+4*CW+1];

    // State
    logic [NUM_KEYS-1:0]            held_reg, held_next;
    logic [NUM_KEYS-1:0]            rep_reg, rep_next;
    logic [TW-1:0]                  last_sample_reg, last_sample_next;
    logic [TW-1:0]                  last_good_reg, last_good_next;
    logic                           finger_reg, finger_next;
    logic [DW-1:0]                  yes_code_reg, yes_code_next;
    logic [DW-1:0]                  no_code_reg, no_code_next;
    logic [tzkeg_pkg::POLL_W-1:0]   poll_reg;
    logic [tzkeg_pkg::HOLD_W-1:0]   hold_reg;
    logic [DW-1:0]                  confirm_reg, abort_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [tzkeg_pkg::OUT_W-1:0]    out_data_reg, out_data_next;

    logic                           accept;
    logic                           sample;
    logic [TW-1:0]                  since_sample, since_good;
    logic signed [LW-1:0]           ly0, ly1;
    tzkeg_pkg::zkeys_t              zkeys;
    logic [NUM_KEYS-1:0]            diff;
    logic                           ev_valid;
    logic [KW-1:0]                  ev_idx;
    logic                           ev_pressed;
    logic [DW-1:0]                  ev_code;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    assign since_sample = now_ms - last_sample_reg;
    assign since_good   = now_ms - last_good_reg;
    assign ly0 = LY_TOP - $signed({{(LW-CW){1'b0}}, p0x});
    assign ly1 = LY_TOP - $signed({{(LW-CW){1'b0}}, p1x});

    always_comb
    begin
        held_next        = held_reg;
        last_sample_next = last_sample_reg;
        last_good_next   = last_good_reg;
        finger_next      = finger_reg;
        yes_code_next    = yes_code_reg;
        no_code_next     = no_code_reg;
        zkeys            = '0;
        sample = (held_reg == rep_reg) &&
                 (since_sample >= TW'(poll_reg));
        if (sample)
        begin
            last_sample_next = now_ms;
            if (read_result[2])
            begin
                // failed read: release only after the hold time
                if (since_good > TW'(hold_reg))
                begin
                    held_next   = '0;
                    finger_next = 1'b0;
                end
            end
            else
            begin
                last_good_next = now_ms;
                if (read_result == 3'd0)
                begin
                    held_next   = '0;
                    finger_next = 1'b0;
                end
                else
                begin
                    if (prompt_active || menu_active)
                    begin
                        // new tap only; a held tap leaves nothing pressed
                        if (!finger_reg)
                        begin
                            yes_code_next = confirm_reg;
                            no_code_next  = abort_reg;
                            zkeys = prompt_active ? tzkeg_pkg::prompt_zone(p0y, ly0)
                                                  : tzkeg_pkg::menu_zone(p0y, ly0);
                        end
                    end
                    else
                    begin
                        zkeys = tzkeg_pkg::game_zone(p0y, ly0);
                        if (read_result[1])
                            zkeys = zkeys | tzkeg_pkg::game_zone(p1y, ly1);
                    end
                    finger_next = 1'b1;
                    held_next   = NUM_KEYS'(zkeys);
                end
            end
        end
    end

    // Lowest changed key wins
    assign diff = held_next ^ rep_reg;

    always_comb
    begin
        ev_valid = 1'b0;
        ev_idx   = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (diff[i])
            begin
                ev_valid = 1'b1;
                ev_idx   = KW'(i);
            end
        end
    end

    always_comb
    begin
        ev_pressed = 1'b0;
        ev_code    = '0;
        rep_next   = rep_reg;
        if (ev_valid)
        begin
            ev_pressed = held_next[ev_idx];
            rep_next[ev_idx] = ~rep_reg[ev_idx];
            if (ev_idx == KW'(tzkeg_pkg::KI_YES))
                ev_code = yes_code_reg;
            else if (ev_idx == KW'(tzkeg_pkg::KI_NO))
                ev_code = no_code_reg;
            else
                ev_code = tzkeg_pkg::base_code(ev_idx);
        end
    end

    // Yes/no events use the codes as they stand after this request's update
    always_comb
    begin
        out_data_next = '0;
        out_data_next[0] = sample;
        out_data_next[1] = ev_valid;
        out_data_next[2] = ev_pressed;
        out_data_next[3+KW-1:3] = ev_idx;
        if (ev_valid && ev_idx == KW'(tzkeg_pkg::KI_YES))
            out_data_next[3+KW+DW-1:3+KW] = yes_code_next;
        else if (ev_valid && ev_idx == KW'(tzkeg_pkg::KI_NO))
            out_data_next[3+KW+DW-1:3+KW] = no_code_next;
        else
            out_data_next[3+KW+DW-1:3+KW] = ev_code;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= '0;
            rep_reg         <= '0;
            last_sample_reg <= '0;
            last_good_reg   <= '0;
            finger_reg      <= 1'b0;
            yes_code_reg    <= tzkeg_pkg::CONFIRM_RST;
            no_code_reg     <= tzkeg_pkg::ABORT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                held_reg        <= held_next;
                rep_reg         <= rep_next;
                last_sample_reg <= last_sample_next;
                last_good_reg   <= last_good_next;
                finger_reg      <= finger_next;
                yes_code_reg    <= yes_code_next;
                no_code_reg     <= no_code_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_reg    <= tzkeg_pkg::POLL_RST;
            hold_reg    <= tzkeg_pkg::HOLD_RST;
            confirm_reg <= tzkeg_pkg::CONFIRM_RST;
            abort_reg   <= tzkeg_pkg::ABORT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tzkeg_pkg::REG_POLL:    poll_reg    <= cfg_data[tzkeg_pkg::POLL_W-1:0];
                tzkeg_pkg::REG_HOLD:    hold_reg    <= cfg_data[tzkeg_pkg::HOLD_W-1:0];
                tzkeg_pkg::REG_CONFIRM: confirm_reg <= cfg_data[DW-1:0];
                tzkeg_pkg::REG_ABORT:   abort_reg   <= cfg_data[DW-1:0];
                default:                poll_reg    <= poll_reg;
            endcase
        end
    end

endmodule
